@@ sv/swps_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and defaults of the sequence window packet store
// no dependencies
package swps_pkg;

   localparam int SWPS_SLOTS         = 64;
   localparam int SWPS_PAYLOAD_WORDS = 256;
   localparam int BYTES_PER_WORD     = 4;
   localparam int CSR_INDEX_W        = 1;

   typedef logic [31:0] seq_type;
   typedef logic [10:0] size_type;
   typedef logic [31:0] word_type;
   typedef logic [7:0]  index_type;
   typedef logic [1:0]  status_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam logic OP_PUT   = 1'b0;
   localparam logic OP_GET   = 1'b1;
   localparam logic KIND_PUT = 1'b0;
   localparam logic KIND_GET = 1'b1;

   localparam status_type ST_STORED   = 2'd0;
   localparam status_type ST_OUTSIDE  = 2'd1;
   localparam status_type ST_EMPTY    = 2'd2;
   localparam status_type ST_MISMATCH = 2'd3;

   localparam csr_index_type CSR_WINDOW_BASE  = 1'b0;
   localparam csr_index_type CSR_WINDOW_COUNT = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } pl_ctl_type;

   // keeps the bytes of a word that lie below the packet size
   function automatic word_type byte_mask(size_type size, index_type idx);
      size_type start;
      size_type n;
      word_type mask;
      start = {1'b0, idx, 2'b00};
      n     = size - start;
      if (size <= start) begin
         mask = '0;
      end else if (n >= 11'd4) begin
         mask = '1;
      end else begin
         unique case (n[1:0])
            2'd1:    mask = 32'h0000_00FF;
            2'd2:    mask = 32'h0000_FFFF;
            2'd3:    mask = 32'h00FF_FFFF;
            default: mask = '0;
         endcase
      end
      return mask;
   endfunction

endpackage

@@ sv/swps_if.sv @@
`timescale 1ns / 1ps
// request and response channel interfaces of the packet store
// depends on swps_pkg
interface swps_req_if;
   import swps_pkg::*;
   logic      valid;
   logic      ready;
   logic      operation;
   seq_type   seq;
   size_type  pkt_bytes;
   word_type  checksum;
   index_type word_index;
   word_type  data_word;
   logic      last;

   modport source(output valid, operation, seq, pkt_bytes, checksum, word_index, data_word,
                  last, input ready);
   modport sink(input valid, operation, seq, pkt_bytes, checksum, word_index, data_word,
                last, output ready);
endinterface

interface swps_rsp_if;
   import swps_pkg::*;
   logic       valid;
   logic       ready;
   logic       kind;
   status_type status;
   seq_type    seq_out;
   size_type   size_out;
   word_type   word_out;

   modport source(output valid, kind, status, seq_out, size_out, word_out, input ready);
   modport sink(input valid, kind, status, seq_out, size_out, word_out, output ready);
endinterface

@@ sv/swps_payload.sv @@
`timescale 1ns / 1ps
// payload word memory: one buffer of words per slot plus the spare
// depends on swps_pkg
module swps_payload #(
   parameter int SLOTS         = swps_pkg::SWPS_SLOTS,
   parameter int PAYLOAD_WORDS = swps_pkg::SWPS_PAYLOAD_WORDS
) (
   input  logic                           clock,
   input  swps_pkg::pl_ctl_type           ctl,
   input  logic [$clog2(SLOTS+1)-1:0]     wr_buf,
   input  logic [$clog2(SLOTS+1)-1:0]     rd_buf,
   input  swps_pkg::index_type            word_index,
   input  swps_pkg::size_type             pkt_bytes,
   input  swps_pkg::word_type             data_word,
   output swps_pkg::word_type             wr_word,
   output swps_pkg::word_type             rd_word
);
   import swps_pkg::*;

   localparam int DEPTH  = (SLOTS + 1) * PAYLOAD_WORDS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   word_type              mem [DEPTH];
   word_type              rd_word_ff;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;

   assign wr_word = data_word & byte_mask(pkt_bytes, word_index);
   assign wr_addr = ADDR_W'(wr_buf * PAYLOAD_WORDS) + ADDR_W'(word_index);
   assign rd_addr = ADDR_W'(rd_buf * PAYLOAD_WORDS) + ADDR_W'(word_index);

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_word;
      end
      if (ctl.rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   assign rd_word = rd_word_ff;

endmodule

@@ sv/seq_window_packet_store_unit.sv @@
`timescale 1ns / 1ps
// Sequence window packet store. Items are taken one at a time: a put word
// without last passes transfer, then window check and payload write; a put
// word with last adds the swap after the slot map read; a get passes transfer,
// window check and slot map read, byte count and payload read, and result.
// A put with last and a get wait while the result register waits on
// rsp_ch.ready. The steps follow the chain of registered reads through the
// slot map, byte count and payload memories. Slot map and byte count entries
// carry valid bits cleared by reset, so no clearing pass follows reset.
// depends on swps_pkg, swps_if and swps_payload
module seq_window_packet_store_unit #(
   parameter int SLOTS         = swps_pkg::SWPS_SLOTS,
   parameter int PAYLOAD_WORDS = swps_pkg::SWPS_PAYLOAD_WORDS
) (
   input  logic                     clock,
   input  logic                     reset,
   swps_req_if.sink                 req_ch,
   swps_rsp_if.source               rsp_ch,
   input  logic                     csr_write,
   input  swps_pkg::csr_index_type  csr_index,
   input  logic [31:0]              csr_wdata
);
   import swps_pkg::*;

   localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BUF_W     = $clog2(SLOTS + 1);
   localparam int NBUF      = SLOTS + 1;
   localparam int MAX_BYTES = PAYLOAD_WORDS * BYTES_PER_WORD;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_MAP  = 2'd2;
   localparam logic [1:0] S_DATA = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [31:0]       window_base_ff;
   logic [6:0]        window_count_ff;

   logic              op_ff;
   seq_type           seq_ff;
   size_type          size_ff;
   word_type          csum_ff;
   index_type         idx_ff;
   word_type          word_ff;
   logic              last_ff;

   logic              win_ok_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic [BUF_W-1:0]  map_mem [SLOTS];
   logic [SLOTS-1:0]  map_vld_ff;
   logic [BUF_W-1:0]  map_rd_ff;
   logic              map_rd_vld_ff;

   size_type          bytes_mem [NBUF];
   logic [NBUF-1:0]   bytes_vld_ff;
   size_type          bytes_rd_ff;
   logic              bytes_rd_vld_ff;

   logic [BUF_W-1:0]  spare_ff, spare_in;
   word_type          sum_ff, sum_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff;
   status_type        rsp_status_ff;
   seq_type           rsp_seq_ff;
   size_type          rsp_size_ff;
   word_type          rsp_word_ff;

   logic              accept;
   logic              out_free;
   logic [31:0]       cnt_lim;
   logic [31:0]       offset;
   logic              in_win;
   logic              idx_ok;
   logic              put_step;
   logic              commit;
   logic              get_read;
   logic              get_emit;
   logic              store_ok;
   logic              rsp_load;
   logic [BUF_W-1:0]  cur_buf;
   status_type        put_status;
   size_type          stored;
   size_type          get_bytes;
   word_type          get_word;
   word_type          masked_word;
   word_type          pl_rd_word;
   pl_ctl_type        pl_ctl;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign cnt_lim = (32'(window_count_ff) > 32'(SLOTS)) ? 32'(SLOTS) : 32'(window_count_ff);
   assign offset  = seq_ff - window_base_ff;
   assign in_win  = (seq_ff >= window_base_ff) && (offset < cnt_lim);
   assign idx_ok  = 32'(idx_ff) < 32'(PAYLOAD_WORDS);

   assign put_step = (state_ff == S_LOOK) && (op_ff == OP_PUT) && idx_ok;
   assign commit   = (state_ff == S_MAP) && (op_ff == OP_PUT) && out_free;
   assign get_read = (state_ff == S_MAP) && (op_ff == OP_GET);
   assign get_emit = (state_ff == S_DATA) && out_free;
   assign store_ok = commit && (put_status == ST_STORED);
   assign rsp_load = commit || get_emit;

   assign cur_buf = map_rd_vld_ff ? map_rd_ff : BUF_W'(slot_ff);

   // put verdict, checked in order
   always_comb begin
      priority if (!win_ok_ff) begin
         put_status = ST_OUTSIDE;
      end else if (size_ff == '0) begin
         put_status = ST_EMPTY;
      end else if (sum_ff != csum_ff) begin
         put_status = ST_MISMATCH;
      end else begin
         put_status = ST_STORED;
      end
   end

   assign stored = (32'(size_ff) > 32'(MAX_BYTES)) ? size_type'(MAX_BYTES) : size_ff;

   assign get_bytes = (win_ok_ff && bytes_rd_vld_ff) ? bytes_rd_ff : '0;
   assign get_word  = (idx_ok && (get_bytes != '0) && (size_type'({idx_ff, 2'b00}) < get_bytes))
                      ? pl_rd_word : '0;

   assign pl_ctl.wr_en = put_step;
   assign pl_ctl.rd_en = get_read;

   swps_payload #(
      .SLOTS         (SLOTS),
      .PAYLOAD_WORDS (PAYLOAD_WORDS)
   ) u_payload (
      .clock      (clock),
      .ctl        (pl_ctl),
      .wr_buf     (spare_ff),
      .rd_buf     (cur_buf),
      .word_index (idx_ff),
      .pkt_bytes  (size_ff),
      .data_word  (word_ff),
      .wr_word    (masked_word),
      .rd_word    (pl_rd_word)
   );

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      spare_in     = spare_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
      if (put_step) begin
         sum_in = sum_ff + masked_word;
      end
      if (commit) begin
         sum_in = '0;
      end
      if (store_ok) begin
         spare_in = cur_buf;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_LOOK;
         end
         S_LOOK: begin
            if (op_ff == OP_GET || last_ff) state_in = S_MAP;
            else                            state_in = S_IDLE;
         end
         S_MAP: begin
            if (op_ff == OP_GET) state_in = S_DATA;
            else if (commit)     state_in = S_IDLE;
         end
         S_DATA: begin
            if (get_emit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         window_base_ff  <= '0;
         window_count_ff <= '0;
         map_vld_ff      <= '0;
         bytes_vld_ff    <= '0;
         spare_ff        <= BUF_W'(SLOTS);
         sum_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         spare_ff     <= spare_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_WINDOW_BASE:  window_base_ff  <= csr_wdata;
               CSR_WINDOW_COUNT: window_count_ff <= csr_wdata[6:0];
               default:          window_base_ff  <= window_base_ff;
            endcase
         end
         if (store_ok) begin
            map_vld_ff[slot_ff]    <= 1'b1;
            bytes_vld_ff[spare_ff] <= 1'b1;
         end
      end
   end

   // item and result registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_ch.operation;
         seq_ff  <= req_ch.seq;
         size_ff <= req_ch.pkt_bytes;
         csum_ff <= req_ch.checksum;
         idx_ff  <= req_ch.word_index;
         word_ff <= req_ch.data_word;
         last_ff <= req_ch.last;
      end
      if (state_ff == S_LOOK) begin
         win_ok_ff <= in_win;
         slot_ff   <= offset[SLOT_W-1:0];
      end
      if (rsp_load) begin
         rsp_seq_ff <= seq_ff;
         if (commit) begin
            rsp_kind_ff   <= KIND_PUT;
            rsp_status_ff <= put_status;
            rsp_size_ff   <= (put_status == ST_STORED) ? stored : '0;
            rsp_word_ff   <= '0;
         end else begin
            rsp_kind_ff   <= KIND_GET;
            rsp_status_ff <= ST_STORED;
            rsp_size_ff   <= get_bytes;
            rsp_word_ff   <= get_word;
         end
      end
   end

   // slot map and byte count memories
   always_ff @(posedge clock) begin
      if (state_ff == S_LOOK) begin
         map_rd_ff     <= map_mem[offset[SLOT_W-1:0]];
         map_rd_vld_ff <= map_vld_ff[offset[SLOT_W-1:0]];
      end
      if (get_read) begin
         bytes_rd_ff     <= bytes_mem[cur_buf];
         bytes_rd_vld_ff <= bytes_vld_ff[cur_buf];
      end
      if (store_ok) begin
         map_mem[slot_ff]    <= spare_ff;
         bytes_mem[spare_ff] <= stored;
      end
   end

   assign req_ch.ready    = (state_ff == S_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.kind     = rsp_kind_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.seq_out  = rsp_seq_ff;
   assign rsp_ch.size_out = rsp_size_ff;
   assign rsp_ch.word_out = rsp_word_ff;

endmodule

@@ sv/swps_checker.sv @@
`timescale 1ns / 1ps
// port level checks of the packet store and their bind to the top level
// depends on swps_pkg and seq_window_packet_store_unit
module swps_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_kind,
   input swps_pkg::status_type   rsp_status,
   input swps_pkg::seq_type      rsp_seq_out,
   input swps_pkg::size_type     rsp_size_out,
   input swps_pkg::word_type     rsp_word_out
);
   import swps_pkg::*;

   // a stalled result transfer keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_status)
         && $stable(rsp_seq_out) && $stable(rsp_size_out) && $stable(rsp_word_out))
      else $error("result changed while stalled");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // get results carry no error status
   a_get_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_GET |-> rsp_status == ST_STORED)
      else $error("get result with error status");

   // put results carry no word and a size only when stored
   a_put_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PUT |->
         rsp_word_out == '0 && (rsp_status == ST_STORED || rsp_size_out == '0))
      else $error("put result fields inconsistent");

   // a new request is only taken with the block idle toward its input
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request transfer while an item is in progress");

endmodule

bind seq_window_packet_store_unit swps_checker u_swps_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_kind     (rsp_ch.kind),
   .rsp_status   (rsp_ch.status),
   .rsp_seq_out  (rsp_ch.seq_out),
   .rsp_size_out (rsp_ch.size_out),
   .rsp_word_out (rsp_ch.word_out)
);
